// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds define SYNTHESIS,
// which turns every check into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AR(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_AR(label, !(cond), msg)

`else

`define ASSERT_AR(label, prop, msg)

`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// File: rtl/phs_pkg.sv
`default_nettype none

package phs_pkg;

	localparam int KEY_BITS     = 64;
	localparam int IN_KEY_BITS  = 64;
	localparam int BUCKETS      = 64;
	localparam int WAYS         = 4;
	localparam int HASH_SHIFT   = 3;
	localparam int BUCKET_BITS  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SLOTS        = BUCKETS * WAYS;
	localparam int CNT_BITS     = $clog2(SLOTS + 1);
	localparam int ROW_BITS     = WAYS * KEY_BITS;
	localparam int OUT_CNT_BITS = 9;

	// The queue depth must be a power of two so that the pointers wrap freely.
	localparam int QDEPTH    = 2;
	localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	typedef enum logic {
		PHS_INSERT = 1'b0,
		PHS_QUERY  = 1'b1
	} phs_kind_t;

	typedef enum logic {
		PHS_IDLE,
		PHS_EVAL
	} phs_state_t;

	typedef struct packed {
		phs_kind_t               kind;
		logic [KEY_BITS-1:0]    key;
		logic [BUCKET_BITS-1:0] bucket;
	} phs_item_t;

	typedef struct packed {
		logic push;
		logic full;
	} phs_push_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} phs_pop_t;

endpackage

`default_nettype wire

// File: rtl/phs_ifs.sv
`default_nettype none

interface phs_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] key;

	modport source (output valid, output kind, output key, input ready);
	modport sink (input valid, input kind, input key, output ready);
endinterface

interface phs_rsp_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic       status;
	logic [8:0] stored_count;

	modport source (output valid, output found, output status, output stored_count,
		input ready);
	modport sink (input valid, input found, input status, input stored_count,
		output ready);
endinterface

`default_nettype wire

// File: rtl/pointer_hash_set.sv
// Set of keys held in 64 buckets of 4 slots each; the bucket is picked by key bits [8:3].
// Each request beat is an insert (kind 0) or a membership query (kind 1) and produces
// exactly one response beat, in order. Inserts go to the lowest free slot without a
// duplicate check, and an insert into a full bucket is refused with status 1. The back
// end reads a bucket row from the key RAM in its idle state and compares and writes it back
// in its evaluate state, finishing each beat before taking another; each request passes
// the front register, the queue and both back-end states. Slot valid bits are flip-flops
// cleared by reset, so the block accepts requests right after reset with no clearing pass.
`default_nettype none

module pointer_hash_set (
	input  wire logic clk,
	input  wire logic arst_n,
	phs_req_if.sink   req,
	phs_rsp_if.source rsp
);
	import phs_pkg::*;

	phs_push_t push_ctl;
	phs_item_t push_item;
	phs_item_t q_item;
	phs_pop_t  pop_ctl;
	logic      q_full;
	logic      q_empty;

	phs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.push_ctl (push_ctl),
		.push_item(push_item),
		.q_full   (q_full)
	);

	phs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_ctl (push_ctl),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop_ctl.pop),
		.pop_item (q_item),
		.empty    (q_empty)
	);

	phs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_item (q_item),
		.pop_ctl(pop_ctl),
		.q_empty(q_empty),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// File: rtl/phs_ram.sv
`default_nettype none

module phs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/phs_queue.sv
`default_nettype none
`include "assert_macros.svh"

module phs_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire phs_pkg::phs_push_t push_ctl,
	input  wire phs_pkg::phs_item_t push_item,
	output logic                    full,
	input  wire logic               pop,
	output phs_pkg::phs_item_t      pop_item,
	output logic                    empty
);
	import phs_pkg::*;

	phs_item_t              entry_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign full     = (cnt_q == QCNT_BITS'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push_ctl.push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

	`ASSERT_NEVER(a_full_seen, push_ctl.full != full, "front and queue disagree on full")
	`ASSERT_NEVER(a_cnt_range, cnt_q > QCNT_BITS'(QDEPTH), "queue count out of range")

endmodule

`default_nettype wire

// File: rtl/phs_front.sv
`default_nettype none

module phs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	phs_req_if.sink            req,
	output phs_pkg::phs_push_t push_ctl,
	output phs_pkg::phs_item_t push_item,
	input  wire logic          q_full
);
	import phs_pkg::*;

	logic                    valid_s1;
	phs_item_t               item_s1;
	logic                    take;
	logic [KEY_BITS-1:0]     key_m;
	logic [IN_KEY_BITS-1:0]  key_ext;

	assign key_m   = req.key[KEY_BITS-1:0];
	assign key_ext = IN_KEY_BITS'(key_m);

	assign req.ready = !valid_s1 || !q_full;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind   <= phs_kind_t'(req.kind);
			item_s1.key    <= key_m;
			item_s1.bucket <= BUCKET_BITS'(key_ext >> HASH_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	assign push_ctl.push = valid_s1;
	assign push_ctl.full = q_full;
	assign push_item     = item_s1;

endmodule

`default_nettype wire

// File: rtl/phs_back.sv
`default_nettype none
`include "assert_macros.svh"

module phs_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire phs_pkg::phs_item_t q_item,
	output phs_pkg::phs_pop_t  pop_ctl,
	input  wire logic          q_empty,
	phs_rsp_if.source          rsp
);
	import phs_pkg::*;

	phs_state_t                       state_q;
	phs_state_t                       state_d;
	phs_item_t                        item_q;
	logic [BUCKETS-1:0][WAYS-1:0]     valid_q;
	logic [CNT_BITS-1:0]              count_q;
	logic [CNT_BITS-1:0]              count_d;
	logic                             rsp_valid_q;
	logic                             found_q;
	logic                             status_q;
	logic [OUT_CNT_BITS-1:0]          cnt_out_q;

	logic                             pop;
	logic                             fire;
	logic [ROW_BITS-1:0]              row;
	logic [ROW_BITS-1:0]              row_new;
	logic [WAYS-1:0]                  row_valid;
	logic                             hit;
	logic                             row_full;
	logic [WAY_BITS-1:0]              free_way;
	logic                             do_insert;

	phs_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(BUCKETS)
	) u_key_ram (
		.clk  (clk),
		.we   (do_insert),
		.waddr(item_q.bucket),
		.wdata(row_new),
		.re   (pop),
		.raddr(q_item.bucket),
		.rdata(row)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PHS_IDLE: begin
				if (!q_empty) begin
					state_d = PHS_EVAL;
				end
			end
			PHS_EVAL: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = PHS_IDLE;
				end
			end
			default: state_d = PHS_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		fire = 1'b0;
		unique case (state_q)
			PHS_IDLE: pop  = !q_empty;
			PHS_EVAL: fire = !rsp_valid_q || rsp.ready;
			default: begin
				pop  = 1'b0;
				fire = 1'b0;
			end
		endcase
	end

	assign row_valid = valid_q[item_q.bucket];
	assign row_full  = &row_valid;
	assign do_insert = fire && (item_q.kind == PHS_INSERT) && !row_full;

	always_comb begin
		hit      = 1'b0;
		free_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (row_valid[w] && (row[w*KEY_BITS +: KEY_BITS] == item_q.key)) begin
				hit = 1'b1;
			end
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!row_valid[w]) begin
				free_way = WAY_BITS'(w);
			end
		end
		row_new = row;
		row_new[free_way*KEY_BITS +: KEY_BITS] = item_q.key;
	end

	assign count_d = do_insert ? count_q + CNT_BITS'(1) : count_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
		if (fire) begin
			found_q   <= (item_q.kind == PHS_QUERY) && hit;
			status_q  <= (item_q.kind == PHS_INSERT) && row_full;
			cnt_out_q <= OUT_CNT_BITS'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PHS_IDLE;
			valid_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (do_insert) begin
				valid_q[item_q.bucket] <= row_valid | (WAYS'(1) << free_way);
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign pop_ctl.pop       = pop;
	assign pop_ctl.empty     = q_empty;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.found         = found_q;
	assign rsp.status        = status_q;
	assign rsp.stored_count  = cnt_out_q;

	`ASSERT_AR(a_count_matches_valid, $countones(valid_q) == int'(count_q), "count drifted from valid bits")
	`ASSERT_AR(a_insert_counts, do_insert |=> count_q == $past(count_q) + CNT_BITS'(1), "insert not counted")
	`ASSERT_NEVER(a_refused_not_found, rsp_valid_q && status_q && found_q, "refused insert reports a hit")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import phs_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_LIMIT  = 10;

	typedef struct packed {
		logic                    found;
		logic                    status;
		logic [OUT_CNT_BITS-1:0] stored_count;
	} set_result_t;

	typedef struct {
		phs_kind_t              op;
		logic [IN_KEY_BITS-1:0] key;
		int unsigned            snd_pct;
		int unsigned            rcv_pct;
		bit                     drain;
		bit                     hold;
	} set_op_t;

	logic clk;
	logic arst_n;

	phs_req_if req_ch ();
	phs_rsp_if rsp_ch ();

	pointer_hash_set u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the set contents.
	logic [KEY_BITS-1:0] slot_key [BUCKETS][WAYS];
	bit   [WAYS-1:0]     slot_used [BUCKETS];
	int unsigned         held_keys;

	set_op_t                pending_ops [$];
	set_result_t            expected_results [$];
	logic [IN_KEY_BITS-1:0] known_keys [$];

	set_op_t     next_op;
	set_result_t want;
	logic        req_fired;
	logic        hold_arm;
	int          hold_left;
	int unsigned rsp_pct;
	int unsigned cur_snd;
	int unsigned cur_rcv;
	bit          next_drain;
	bit          next_hold;
	int          fail_count;
	int          cycle_count;
	int unsigned hot [4];

	function automatic set_result_t apply_set_op(input phs_kind_t op,
			input logic [IN_KEY_BITS-1:0] raw_key);
		logic [KEY_BITS-1:0] k;
		int unsigned b;
		bit placed;
		set_result_t r;
		k = raw_key[KEY_BITS-1:0];
		b = 32'(k[HASH_SHIFT +: BUCKET_BITS]);
		placed = 1'b0;
		r = '0;
		if (op == PHS_INSERT) begin
			r.status = 1'b1;
			for (int w = 0; w < WAYS; w++) begin
				if (!placed && !slot_used[b][w]) begin
					slot_key[b][w] = k;
					slot_used[b][w] = 1'b1;
					held_keys++;
					placed = 1'b1;
					r.status = 1'b0;
				end
			end
		end else begin
			for (int w = 0; w < WAYS; w++) begin
				if (slot_used[b][w] && slot_key[b][w] == k)
					r.found = 1'b1;
			end
		end
		r.stored_count = held_keys[OUT_CNT_BITS-1:0];
		return r;
	endfunction

	function automatic logic [IN_KEY_BITS-1:0] key_in_bucket(input int unsigned b);
		logic [IN_KEY_BITS-1:0] k;
		k = {$urandom, $urandom};
		k[HASH_SHIFT +: BUCKET_BITS] = b[BUCKET_BITS-1:0];
		return k;
	endfunction

	function automatic logic [IN_KEY_BITS-1:0] query_key(input int unsigned b);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50 && known_keys.size() != 0)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		else if (r < 80)
			return key_in_bucket(b);
		else
			return {$urandom, $urandom};
	endfunction

	function automatic logic [IN_KEY_BITS-1:0] insert_key(input int unsigned b);
		if ($urandom_range(99) < 20 && known_keys.size() != 0)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		else
			return key_in_bucket(b);
	endfunction

	task automatic queue_op(input phs_kind_t op, input logic [IN_KEY_BITS-1:0] k);
		set_op_t item;
		item.op = op;
		item.key = k;
		item.snd_pct = cur_snd;
		item.rcv_pct = cur_rcv;
		item.drain = next_drain;
		item.hold = next_hold;
		next_drain = 1'b0;
		next_hold = 1'b0;
		pending_ops.push_back(item);
		if (op == PHS_INSERT)
			known_keys.push_back(k);
	endtask

	task automatic queue_random_ops(input int count, input bit hot_only);
		int unsigned b;
		for (int i = 0; i < count; i++) begin
			b = hot_only ? hot[$urandom_range(3)] : $urandom_range(BUCKETS - 1);
			if ($urandom_range(99) < 55)
				queue_op(PHS_INSERT, insert_key(b));
			else
				queue_op(PHS_QUERY, query_key(b));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A request beat is held until it is taken; idle gaps only fall between beats.
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_fired)) begin
			if (pending_ops.size() != 0
					&& !(pending_ops[0].drain && expected_results.size() != 0)
					&& $urandom_range(99) >= pending_ops[0].snd_pct) begin
				next_op = pending_ops.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= next_op.op;
				req_ch.key <= next_op.key;
				rsp_pct <= next_op.rcv_pct;
				hold_arm <= next_op.hold;
			end else begin
				req_ch.valid <= 1'b0;
				hold_arm <= 1'b0;
			end
		end else begin
			hold_arm <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (hold_arm)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		rsp_ch.ready <= arst_n && !hold_arm && hold_left == 0
			&& $urandom_range(99) >= rsp_pct;
	end

	// Results are checked before the new request is predicted, so a result beat
	// with nothing outstanding is always caught.
	always @(posedge clk) begin
		req_fired <= arst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOW_LIMIT)
					$display("unexpected result: found=%0b status=%0b stored_count=%0d",
						rsp_ch.found, rsp_ch.status, rsp_ch.stored_count);
			end else begin
				want = expected_results.pop_front();
				if (rsp_ch.found !== want.found || rsp_ch.status !== want.status
						|| rsp_ch.stored_count !== want.stored_count) begin
					fail_count++;
					if (fail_count <= SHOW_LIMIT)
						$display("mismatch: expected found=%0b status=%0b stored_count=%0d, %s",
							want.found, want.status, want.stored_count,
							$sformatf("got found=%0b status=%0b stored_count=%0d",
							rsp_ch.found, rsp_ch.status, rsp_ch.stored_count));
				end
			end
		end
		if (arst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
			expected_results.push_back(apply_set_op(phs_kind_t'(req_ch.kind), req_ch.key));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = PHS_INSERT;
		req_ch.key = '0;
		rsp_ch.ready = 1'b0;
		req_fired = 1'b0;
		hold_arm = 1'b0;
		hold_left = 0;
		rsp_pct = 0;
		held_keys = 0;
		fail_count = 0;
		cycle_count = 0;
		next_drain = 1'b0;
		next_hold = 1'b0;
		for (int b = 0; b < BUCKETS; b++)
			slot_used[b] = '0;
		for (int i = 0; i < 4; i++)
			hot[i] = $urandom_range(BUCKETS - 1);

		cur_snd = 26;
		cur_rcv = 85;
		queue_op(PHS_INSERT, 64'h0);
		queue_op(PHS_QUERY, 64'h0);
		queue_op(PHS_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_op(PHS_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_op(PHS_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_op(PHS_INSERT, 64'h0);
		queue_op(PHS_INSERT, 64'h0);
		queue_op(PHS_INSERT, 64'h0);
		queue_op(PHS_INSERT, 64'h7);
		queue_op(PHS_QUERY, 64'h7);
		queue_op(PHS_QUERY, 64'h8000_0000_0000_0000);
		queue_op(PHS_QUERY, 64'h0);
		queue_op(PHS_INSERT, 64'h8);
		queue_op(PHS_QUERY, 64'h1_0000_0008);
		queue_op(PHS_QUERY, 64'hFFFF_FFFF_FFFF_FFF8);
		queue_op(PHS_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_op(PHS_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_op(PHS_INSERT, 64'h5555_5555_5555_5555);
		queue_op(PHS_QUERY, 64'h5555_5555_5555_5555);
		queue_random_ops(45, 1'b1);

		cur_snd = 85;
		cur_rcv = 26;
		next_drain = 1'b1;
		queue_random_ops(45, 1'b0);

		// Sweeping every bucket once per way leaves the whole set full.
		cur_snd = 0;
		cur_rcv = 0;
		next_hold = 1'b1;
		for (int pass = 0; pass < WAYS; pass++) begin
			for (int b = 0; b < BUCKETS; b++) begin
				queue_op(PHS_INSERT, key_in_bucket(b));
				if (b % 8 == 7)
					queue_op(PHS_QUERY, query_key($urandom_range(BUCKETS - 1)));
			end
		end
		for (int i = 0; i < 4; i++) begin
			queue_op(PHS_INSERT, {$urandom, $urandom});
			queue_op(PHS_QUERY, query_key($urandom_range(BUCKETS - 1)));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		fail_count += expected_results.size();
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/phs_pkg.sv
rtl/phs_ifs.sv
rtl/phs_ram.sv
rtl/phs_queue.sv
rtl/phs_front.sv
rtl/phs_back.sv
rtl/pointer_hash_set.sv
tb/sv/tb.sv
